// ===== rtl/name_intern_hash_table_unit_assert.svh =====
// assertion macros used by the checker file
// depends on nothing; included by nih_checker
`ifndef NAME_INTERN_HASH_TABLE_UNIT_ASSERT_SVH
`define NAME_INTERN_HASH_TABLE_UNIT_ASSERT_SVH

// checked only outside reset
`define NIH_AST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nih assertion failed");

// checked in reset as well
`define NIH_AST_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nih reset assertion failed");

`endif

// ===== rtl/nih_pkg.sv =====
// types, codes and the hash step for the name intern table
// no dependencies
package nih_pkg;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic       bank;
        logic       bad;
        logic [8:0] n;
        logic [31:0] hash;
    } job_t;

    typedef struct packed {
        logic clearing;
        logic done;
    } bk_stat_t;

    typedef enum logic [4:0] {
        B_CLEAR, B_IDLE, B_PROBE_RD, B_PROBE_CHK, B_CMP_RD, B_CMP_CHK,
        B_INS_RD, B_INS_WR, B_GROW_CLR, B_GROW_RD, B_GROW_CHK, B_HLEN,
        B_HASH_RD, B_HASH_CHK, B_REH_RD, B_REH_CHK, B_RESULT
    } bk_state_t;

    localparam logic [1:0]  ST_FOUND  = 2'd0;
    localparam logic [1:0]  ST_NEW    = 2'd1;
    localparam logic [1:0]  ST_FULL   = 2'd2;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [8:0]  POS_SAT   = 9'd511;

    function automatic logic [31:0] djb_step(input logic [31:0] h, input logic [7:0] b);
        return ((h << 5) + h) ^ {24'd0, b};
    endfunction

endpackage

// ===== rtl/name_intern_hash_table_unit.sv =====
// name intern table: bytes are taken one per cycle while fewer than two names are pending
// a name then passes a read and a check state per probed slot and per compared byte,
// set by the single read port of the slot and byte rams; a new name adds a read
// and a write state per byte copied; growth clears the new table (one slot a cycle)
// and rehashes every entry byte by byte
// after reset a clearing pass over the INIT_SLOTS slots runs with s_ready low
module name_intern_hash_table_unit #(
    parameter int INIT_SLOTS     = 512,
    parameter int MAX_SLOTS      = 8192,
    parameter int STORE_BYTES    = 65536,
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nih_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output nih_pkg::res_t m_data
);
    import nih_pkg::*;
    localparam int BAW = $clog2(MAX_NAME_BYTES) + 1;

    logic           buf_we;
    logic [BAW-1:0] buf_waddr, buf_raddr;
    logic [7:0]     buf_wdata, buf_rdata;
    logic           push, pop, q_empty;
    job_t           push_job, head;
    bk_stat_t       stat;

    nih_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .buf_we(buf_we), .buf_waddr(buf_waddr), .buf_wdata(buf_wdata),
        .push(push), .push_job(push_job), .stat(stat)
    );

    nih_ram #(.WIDTH(8), .DEPTH(2*MAX_NAME_BYTES)) u_namebuf (
        .clk(aclk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata)
    );

    nih_jobq u_jobq (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_job(push_job),
        .pop(pop), .empty(q_empty), .head(head)
    );

    nih_back #(
        .INIT_SLOTS(INIT_SLOTS), .MAX_SLOTS(MAX_SLOTS),
        .STORE_BYTES(STORE_BYTES), .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_head(head), .q_pop(pop),
        .buf_raddr(buf_raddr), .buf_rdata(buf_rdata),
        .stat(stat),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ===== rtl/nih_ram.sv =====
// generic simple dual port ram, registered read
// no dependencies
module nih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/nih_front.sv =====
// front: takes name bytes, buffers them, hashes, queues finished names
// depends on nih_pkg
module nih_front #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  nih_pkg::in_t                         s_data,
    output logic                                 buf_we,
    output logic [$clog2(MAX_NAME_BYTES):0]      buf_waddr,
    output logic [7:0]                           buf_wdata,
    output logic                                 push,
    output nih_pkg::job_t                        push_job,
    input  nih_pkg::bk_stat_t                    stat
);
    import nih_pkg::*;
    localparam int BW = $clog2(MAX_NAME_BYTES);

    logic [8:0]  pos_reg, pos_next;
    logic [31:0] hash_reg, hash_next;
    logic [7:0]  len_reg, len_next;
    logic        bank_reg, bank_next;
    logic [1:0]  outst_reg, outst_next;
    logic        acc;
    logic [9:0]  n;
    logic [7:0]  lenb;

    assign s_ready   = !stat.clearing && (outst_reg < 2'd2);
    assign acc       = s_valid && s_ready;
    assign n         = {1'b0, pos_reg} + 10'd1;
    assign lenb      = (pos_reg == 9'd0) ? s_data.name_byte : len_reg;
    assign buf_we    = acc && (pos_reg < 9'(MAX_NAME_BYTES));
    assign buf_waddr = {bank_reg, pos_reg[BW-1:0]};
    assign buf_wdata = s_data.name_byte;
    assign push      = acc && s_data.last_byte;

    always_comb begin
        push_job.bank = bank_reg;
        push_job.n    = n[8:0];
        push_job.hash = hash_reg;
        push_job.bad  = (n > 10'(MAX_NAME_BYTES)) || ({2'd0, lenb} != (n - 10'd1));
    end

    always_comb begin
        pos_next   = pos_reg;
        hash_next  = hash_reg;
        len_next   = len_reg;
        bank_next  = bank_reg;
        outst_next = outst_reg + {1'b0, push} - {1'b0, stat.done};
        if (acc) begin
            if (pos_reg == 9'd0) begin
                len_next = s_data.name_byte;
            end
            if (s_data.last_byte) begin
                pos_next  = 9'd0;
                hash_next = HASH_SEED;
                bank_next = !bank_reg;
            end else begin
                if (pos_reg >= 9'd1 && pos_reg < 9'(MAX_NAME_BYTES)) begin
                    hash_next = djb_step(hash_reg, s_data.name_byte);
                end
                if (pos_reg < POS_SAT) begin
                    pos_next = pos_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 9'd0;
            hash_reg  <= HASH_SEED;
            bank_reg  <= 1'b0;
            outst_reg <= 2'd0;
        end else begin
            pos_reg   <= pos_next;
            hash_reg  <= hash_next;
            bank_reg  <= bank_next;
            outst_reg <= outst_next;
        end
        len_reg <= len_next;
    end
endmodule

// ===== rtl/nih_jobq.sv =====
// two entry queue of finished names between front and back
// depends on nih_pkg
module nih_jobq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  nih_pkg::job_t push_job,
    input  logic          pop,
    output logic          empty,
    output nih_pkg::job_t head
);
    import nih_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            mem_reg[wp_reg] <= push_job;
        end
    end
endmodule

// ===== rtl/nih_back.sv =====
// back: probes the slot table, compares, inserts, grows, drives results
// depends on nih_pkg and nih_ram
module nih_back #(
    parameter int INIT_SLOTS     = 512,
    parameter int MAX_SLOTS      = 8192,
    parameter int STORE_BYTES    = 65536,
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  nih_pkg::job_t                   q_head,
    output logic                            q_pop,
    output logic [$clog2(MAX_NAME_BYTES):0] buf_raddr,
    input  logic [7:0]                      buf_rdata,
    output nih_pkg::bk_stat_t               stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output nih_pkg::res_t                   m_data
);
    import nih_pkg::*;
    localparam int SLW = $clog2(MAX_SLOTS);
    localparam int SAW = $clog2(STORE_BYTES);
    localparam int BW  = $clog2(MAX_NAME_BYTES);
    localparam logic [SLW-1:0] INIT_MASK = SLW'(INIT_SLOTS - 1);
    localparam logic [SLW-1:0] MAX_MASK  = SLW'(MAX_SLOTS - 1);
    localparam logic [SAW:0]   STORE_TOT = (SAW+1)'(STORE_BYTES);

    bk_state_t      state_reg, state_next;
    logic           cur_reg, cur_next;
    logic [SLW-1:0] mask_reg, mask_next;
    logic [SLW-1:0] count_reg, count_next;
    logic [SAW:0]   fill_reg, fill_next;
    job_t           job_reg, job_next;
    logic [SLW-1:0] s_reg, s_next;
    logic [SLW-1:0] step_reg, step_next;
    logic [SLW:0]   tries_reg, tries_next;
    logic [SAW-1:0] off_reg, off_next;
    logic [8:0]     idx_reg, idx_next;
    logic [SLW-1:0] g_reg, g_next;
    logic [7:0]     len_reg, len_next;
    logic [31:0]    h_reg, h_next;
    res_t           res_reg, res_next;
    logic           mv_reg, mv_next;
    res_t           md_reg, md_next;

    logic           slot_we;
    logic [SLW:0]   slot_waddr, slot_raddr;
    logic [SAW:0]   slot_wdata, slot_rdata;
    logic           st_we;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [7:0]     st_wdata, st_rdata;

    logic [SLW-1:0] nmask, half;
    logic [SLW:0]   cnt1;
    logic [SAW:0]   pos_sum, room;
    logic           probe_next, grow_next, done;

    assign nmask   = {mask_reg[SLW-2:0], 1'b1};
    assign half    = mask_reg >> 1;
    assign cnt1    = {1'b0, count_reg} + {{SLW{1'b0}}, 1'b1};
    assign pos_sum = {1'b0, off_reg} + (SAW+1)'(idx_reg);
    assign room    = STORE_TOT - fill_reg;

    nih_ram #(.WIDTH(SAW+1), .DEPTH(2*MAX_SLOTS)) u_slots (
        .clk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    nih_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    assign stat.clearing = (state_reg == B_CLEAR);
    assign stat.done     = done;
    assign m_valid       = mv_reg;
    assign m_data        = md_reg;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        mask_next  = mask_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        job_next   = job_reg;
        s_next     = s_reg;
        step_next  = step_reg;
        tries_next = tries_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        g_next     = g_reg;
        len_next   = len_reg;
        h_next     = h_reg;
        res_next   = res_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        slot_we    = 1'b0;
        slot_waddr = {cur_reg, s_reg};
        slot_wdata = '0;
        slot_raddr = {cur_reg, s_reg};
        st_we      = 1'b0;
        st_waddr   = SAW'(pos_sum);
        st_wdata   = buf_rdata;
        st_raddr   = SAW'(pos_sum);
        buf_raddr  = {job_reg.bank, idx_reg[BW-1:0]};
        q_pop      = 1'b0;
        done       = 1'b0;
        probe_next = 1'b0;
        grow_next  = 1'b0;

        unique case (state_reg)
            B_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = {cur_reg, g_reg};
                if (g_reg == INIT_MASK) begin
                    g_next     = '0;
                    state_next = B_IDLE;
                end else begin
                    g_next = g_reg + 1'b1;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    s_next     = q_head.hash[SLW-1:0] & mask_reg;
                    step_next  = {{(SLW-1){1'b0}}, 1'b1};
                    tries_next = '0;
                    if (q_head.bad) begin
                        res_next   = '{handle: 16'd0, status: ST_FULL};
                        state_next = B_RESULT;
                    end else begin
                        state_next = B_PROBE_RD;
                    end
                end
            end
            B_PROBE_RD: begin
                state_next = B_PROBE_CHK;
            end
            B_PROBE_CHK: begin
                if (slot_rdata[SAW]) begin
                    off_next   = slot_rdata[SAW-1:0];
                    idx_next   = 9'd0;
                    state_next = B_CMP_RD;
                end else if (room < (SAW+1)'(job_reg.n)
                        || (cnt1 > {1'b0, half} && mask_reg == MAX_MASK)) begin
                    res_next   = '{handle: 16'd0, status: ST_FULL};
                    state_next = B_RESULT;
                end else begin
                    slot_we    = 1'b1;
                    slot_wdata = {1'b1, fill_reg[SAW-1:0]};
                    off_next   = fill_reg[SAW-1:0];
                    res_next   = '{handle: 16'(fill_reg[SAW-1:0]), status: ST_NEW};
                    idx_next   = 9'd0;
                    state_next = B_INS_RD;
                end
            end
            B_CMP_RD: begin
                if (pos_sum >= fill_reg) begin
                    probe_next = 1'b1;
                end else begin
                    state_next = B_CMP_CHK;
                end
            end
            B_CMP_CHK: begin
                if (st_rdata != buf_rdata) begin
                    probe_next = 1'b1;
                end else if (idx_reg + 9'd1 == job_reg.n) begin
                    res_next   = '{handle: 16'(off_reg), status: ST_FOUND};
                    state_next = B_RESULT;
                end else begin
                    idx_next   = idx_reg + 9'd1;
                    state_next = B_CMP_RD;
                end
            end
            B_INS_RD: begin
                state_next = B_INS_WR;
            end
            B_INS_WR: begin
                st_we = 1'b1;
                if (idx_reg + 9'd1 == job_reg.n) begin
                    fill_next  = fill_reg + (SAW+1)'(job_reg.n);
                    count_next = cnt1[SLW-1:0];
                    g_next     = '0;
                    if (cnt1 > {1'b0, half} && mask_reg != MAX_MASK) begin
                        state_next = B_GROW_CLR;
                    end else begin
                        state_next = B_RESULT;
                    end
                end else begin
                    idx_next   = idx_reg + 9'd1;
                    state_next = B_INS_RD;
                end
            end
            B_GROW_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = {!cur_reg, g_reg};
                if (g_reg == nmask) begin
                    g_next     = '0;
                    state_next = B_GROW_RD;
                end else begin
                    g_next = g_reg + 1'b1;
                end
            end
            B_GROW_RD: begin
                slot_raddr = {cur_reg, g_reg};
                state_next = B_GROW_CHK;
            end
            B_GROW_CHK: begin
                if (slot_rdata[SAW]) begin
                    off_next   = slot_rdata[SAW-1:0];
                    st_raddr   = slot_rdata[SAW-1:0];
                    state_next = B_HLEN;
                end else begin
                    grow_next = 1'b1;
                end
            end
            B_HLEN: begin
                len_next   = st_rdata;
                h_next     = HASH_SEED;
                idx_next   = 9'd1;
                state_next = B_HASH_RD;
            end
            B_HASH_RD: begin
                if (idx_reg >= {1'b0, len_reg} || pos_sum >= fill_reg) begin
                    s_next     = h_reg[SLW-1:0] & nmask;
                    step_next  = {{(SLW-1){1'b0}}, 1'b1};
                    state_next = B_REH_RD;
                end else begin
                    state_next = B_HASH_CHK;
                end
            end
            B_HASH_CHK: begin
                h_next     = djb_step(h_reg, st_rdata);
                idx_next   = idx_reg + 9'd1;
                state_next = B_HASH_RD;
            end
            B_REH_RD: begin
                slot_raddr = {!cur_reg, s_reg};
                state_next = B_REH_CHK;
            end
            B_REH_CHK: begin
                if (slot_rdata[SAW]) begin
                    s_next     = (s_reg + step_reg) & nmask;
                    step_next  = step_reg + 1'b1;
                    state_next = B_REH_RD;
                end else begin
                    slot_we    = 1'b1;
                    slot_waddr = {!cur_reg, s_reg};
                    slot_wdata = {1'b1, off_reg};
                    grow_next  = 1'b1;
                end
            end
            B_RESULT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    md_next    = res_reg;
                    done       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (probe_next) begin
            s_next     = (s_reg + step_reg) & mask_reg;
            step_next  = step_reg + 1'b1;
            tries_next = tries_reg + 1'b1;
            if (tries_reg + 1'b1 > {1'b0, mask_reg}) begin
                res_next   = '{handle: 16'd0, status: ST_FULL};
                state_next = B_RESULT;
            end else begin
                state_next = B_PROBE_RD;
            end
        end

        if (grow_next) begin
            if (g_reg == mask_reg) begin
                cur_next   = !cur_reg;
                mask_next  = nmask;
                state_next = B_RESULT;
            end else begin
                g_next     = g_reg + 1'b1;
                state_next = B_GROW_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            cur_reg   <= 1'b0;
            mask_reg  <= INIT_MASK;
            count_reg <= '0;
            fill_reg  <= '0;
            g_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            mask_reg  <= mask_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            g_reg     <= g_next;
            mv_reg    <= mv_next;
        end
        job_reg   <= job_next;
        s_reg     <= s_next;
        step_reg  <= step_next;
        tries_reg <= tries_next;
        off_reg   <= off_next;
        idx_reg   <= idx_next;
        len_reg   <= len_next;
        h_reg     <= h_next;
        res_reg   <= res_next;
        md_reg    <= md_next;
    end
endmodule

// ===== rtl/nih_checker.sv =====
// port level checks for the name intern table, bound to the top level
// depends on nih_pkg and name_intern_hash_table_unit_assert.svh
`include "name_intern_hash_table_unit_assert.svh"
module nih_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input nih_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input nih_pkg::res_t m_data
);
    import nih_pkg::*;

    `NIH_AST(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `NIH_AST(a_code, aclk, aresetn, m_valid |-> m_data.status != 2'd3)
    `NIH_AST(a_full0, aclk, aresetn, m_valid && m_data.status == ST_FULL |-> m_data.handle == 16'd0)
    `NIH_AST_RST(a_rst_out, aclk, !aresetn |=> !m_valid && !s_ready)
endmodule

bind name_intern_hash_table_unit nih_checker u_chk (.*);
